/* rtl/lfir_pkg.sv */
// Shared types and constants for the line FIR with border modes.
package lfir_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int TAP_BITS     = 16;
  localparam int PROD_W       = SAMPLE_BITS + TAP_BITS;
  localparam int CFG_DATA_W   = 48;
  localparam int CFG_IDX_W    = 3;
  localparam int RADIUS_W     = 3;
  localparam int MODE_W       = 2;
  localparam int FRAC_BITS    = 14;
  localparam int ROUND_BIAS   = 1 << (FRAC_BITS - 1);
  localparam int SAMP_MAX     = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAMP_MIN     = -(1 << (SAMPLE_BITS - 1));
  localparam int TAPS_PER_REG = 3;
  localparam int NUM_TAP_REGS = 5;
  localparam logic [CFG_DATA_W-1:0] TAPS0_RESET = CFG_DATA_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAPS_0_2   = 3'd0,
    REG_TAPS_3_5   = 3'd1,
    REG_TAPS_6_8   = 3'd2,
    REG_TAPS_9_11  = 3'd3,
    REG_TAPS_12_14 = 3'd4,
    REG_RADIUS     = 3'd5,
    REG_MODE       = 3'd6,
    REG_BVAL       = 3'd7
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ZERO  = 2'd0,
    MODE_CONST = 2'd1,
    MODE_EDGE  = 2'd2
  } border_mode_t;

  // Where a window cell's value comes from: the left border (outside the
  // line, before its start), a real sample, or the right border (flush).
  typedef enum logic [1:0] {
    TAG_LEFT  = 2'd0,
    TAG_REAL  = 2'd1,
    TAG_RIGHT = 2'd2
  } cell_tag_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_line;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          end_of_line;
    logic                          clipped;
  } out_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    cell_tag_t                     tag;
  } cell_word_t;

  typedef struct packed {
    logic shift;
    logic restart;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } border_t;

endpackage

/* rtl/lfir_cell.sv */
// One window cell: holds a sample and its tag, and forms its tap product.
module lfir_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lfir_pkg::cell_ctl_t                 ctl,
  input  lfir_pkg::cell_word_t                word_in,
  output lfir_pkg::cell_word_t                word_out,
  input  lfir_pkg::border_t                   border,
  input  logic signed [lfir_pkg::TAP_BITS-1:0] tap,
  input  logic                                tap_en,
  output logic signed [lfir_pkg::PROD_W-1:0]  prod
);
  import lfir_pkg::*;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  cell_tag_t                     tag_r;
  logic signed [SAMPLE_BITS-1:0] operand;
  logic signed [PROD_W-1:0]      prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= TAG_LEFT;
    end else if (ctl.shift) begin
      tag_r <= ctl.restart ? TAG_LEFT : word_in.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      sample_r <= word_in.sample;
    end
  end

  always_comb begin
    case (tag_r)
      TAG_REAL:  operand = sample_r;
      TAG_LEFT:  operand = border.left;
      TAG_RIGHT: operand = border.right;
      default:   operand = '0;
    endcase
  end

  // The multiply stands alone so that both factors stay signed.
  always_ff @(posedge clk) begin
    if (tap_en) begin
      prod_r <= operand * tap;
    end else begin
      prod_r <= '0;
    end
  end

  assign word_out.sample = sample_r;
  assign word_out.tag    = tag_r;
  assign prod            = prod_r;

endmodule

/* rtl/lfir_sum.sv */
// Registered adder tree that sums the cell products; every tree level is registered.
module lfir_sum #(
  parameter int N_IN  = 15,
  parameter int IN_W  = 32,
  parameter int OUT_W = 36
) (
  input  logic                    clk,
  input  logic signed [IN_W-1:0]  prod [N_IN],
  output logic signed [OUT_W-1:0] sum
);
  import lfir_pkg::*;

  localparam int LEVELS = $clog2(N_IN);
  localparam int LEAVES = 1 << LEVELS;

  // Heap order: node 1 is the root, leaves sit at LEAVES .. 2*LEAVES-1.
  logic signed [OUT_W-1:0] node [1:2*LEAVES-1];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < N_IN) begin : g_used
      assign node[LEAVES + i] = OUT_W'(prod[i]);
    end else begin : g_pad
      assign node[LEAVES + i] = '0;
    end
  end

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    always_ff @(posedge clk) begin
      node[n] <= node[2*n] + node[2*n + 1];
    end
  end

  assign sum = node[1];

endmodule

/* rtl/lfir_fifo.sv */
// Result queue that decouples the filter pipeline from the output stall.
module lfir_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  lfir_pkg::out_word_t wr_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lfir_pkg::out_word_t out_data
);
  import lfir_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  out_word_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W:0]     count_r;
  logic               rd_en;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign rd_en     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + (PTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (PTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/line_fir_with_border_modes.sv */
// Top level of the streaming line FIR with zero, constant and edge borders.
//
// Samples enter on the in_ channel, one word per cycle while in_stall is low,
// with last_in_line set on the final sample of each line. Each accepted word
// shifts a chain of 2*MAX_RADIUS+1 cells; once R+1 samples of a line are held,
// every word gives one filtered result. After the last sample of a line the
// chain shifts R more times with right-border values to flush the remaining
// positions, holding in_stall high until the flush ends. A line shorter than
// R+1 samples yields all of its results during that flush.
// Throughput is one word per cycle outside the flush while queue slots are
// free. An accepted word's result reaches out_ through the window cell
// register, the product register, the adder tree levels and the queue write.
// Results wait in a queue of 8 words (at the default); when out_stall holds
// them there, intake continues until every queue slot is claimed by a word in
// flight, and then in_stall rises.
// Reset loads the register defaults (tap 0 = 1.0, all else zero), empties the
// queue and marks every cell as outside the line; no clearing pass is needed.
// Configuration words on cfg_ are always taken; write them only when idle.
module line_fir_with_border_modes #(
  parameter int MAX_RADIUS = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lfir_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lfir_pkg::out_word_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lfir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lfir_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lfir_pkg::*;

  localparam int NCELLS     = 2 * MAX_RADIUS + 1;
  localparam int TREE_LV    = $clog2(NCELLS);
  localparam int ACC_W      = PROD_W + TREE_LV;
  localparam int FIFO_DEPTH = 1 << $clog2(TREE_LV + 4);
  localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);
  localparam int SEEN_W     = $clog2(NCELLS + 1);

  // Configuration registers.
  logic [CFG_DATA_W-1:0]         taps_r [NUM_TAP_REGS];
  logic [RADIUS_W-1:0]           radius_r;
  logic [MODE_W-1:0]             mode_r;
  logic signed [SAMPLE_BITS-1:0] bval_r;

  // Line sequencing state.
  logic [SEEN_W-1:0]             seen_r;
  logic [SEEN_W-1:0]             seen_inc;
  logic signed [SAMPLE_BITS-1:0] first_r;
  logic signed [SAMPLE_BITS-1:0] newest_r;
  logic                          flush_r;
  logic [RADIUS_W-1:0]           vstep_r;
  logic [RADIUS_W-1:0]           vstep_inc;
  logic [RADIUS_W-1:0]           r_eff;

  // Issue stage and result sideband that runs beside the adder tree.
  logic                          iss_v_r;
  logic                          iss_eol_r;
  logic                          pv_r [TREE_LV+1];
  logic                          pe_r [TREE_LV+1];
  logic [PEND_W-1:0]             pend_r;

  logic                          credit_ok;
  logic                          adv_real;
  logic                          adv_virt;
  logic                          shift;
  logic                          restart;
  logic                          emit;
  logic                          emit_eol;
  logic                          deliver;

  cell_word_t                    head_word;
  cell_word_t                    word_d [NCELLS];
  cell_word_t                    word_q [NCELLS];
  border_t                       border;
  logic signed [TAP_BITS-1:0]    tap_w [NCELLS];
  logic                          tap_en [NCELLS];
  logic signed [PROD_W-1:0]      prod [NCELLS];

  logic signed [ACC_W-1:0]       tree_sum;
  logic signed [ACC_W-1:0]       biased;
  logic signed [ACC_W-1:0]       shifted;
  logic                          too_high;
  logic                          too_low;
  out_word_t                     result;
  logic                          fifo_wr;

  // ---------------------------------------------------------------------------
  // Configuration port. Every write is taken in the cycle it is offered.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TAP_REGS; i++) begin
        taps_r[i] <= (i == 0) ? TAPS0_RESET : '0;
      end
      radius_r  <= '0;
      mode_r    <= '0;
      bval_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TAPS_0_2:   taps_r[0] <= cfg_data;
        REG_TAPS_3_5:   taps_r[1] <= cfg_data;
        REG_TAPS_6_8:   taps_r[2] <= cfg_data;
        REG_TAPS_9_11:  taps_r[3] <= cfg_data;
        REG_TAPS_12_14: taps_r[4] <= cfg_data;
        REG_RADIUS:     radius_r  <= cfg_data[RADIUS_W-1:0];
        REG_MODE:       mode_r    <= cfg_data[MODE_W-1:0];
        REG_BVAL:       bval_r    <= cfg_data[SAMPLE_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // A radius beyond what the chain holds is clamped to the chain's reach.
  assign r_eff = (int'(radius_r) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : radius_r;

  // Border values for cells before the line start and for flush cells.
  // The unused mode code behaves as zero padding.
  always_comb begin
    case (border_mode_t'(mode_r))
      MODE_CONST: begin
        border.left  = bval_r;
        border.right = bval_r;
      end
      MODE_EDGE: begin
        border.left  = first_r;
        border.right = newest_r;
      end
      default: begin
        border.left  = '0;
        border.right = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Window advance. A real sample or, during the flush, a right-border word
  // enters cell 0. Every advance that emits a result claims one queue slot in
  // advance, so that the result always has room even under a long output stall.
  // ---------------------------------------------------------------------------
  assign credit_ok = (pend_r != PEND_W'(FIFO_DEPTH));
  assign in_stall  = flush_r || !credit_ok;
  assign adv_real  = in_valid && !in_stall;
  assign adv_virt  = flush_r && credit_ok;
  assign shift     = adv_real || adv_virt;
  assign restart   = adv_real && (seen_r == '0);
  assign seen_inc  = (seen_r == SEEN_W'(NCELLS)) ? seen_r : seen_r + SEEN_W'(1);
  assign vstep_inc = vstep_r + RADIUS_W'(1);

  // In the flush frame the output position stays at the chain's center, so
  // tap j always meets cell j. The flush step emits once the position it
  // reaches lies inside the line.
  always_comb begin
    emit     = 1'b0;
    emit_eol = 1'b0;
    if (adv_real) begin
      emit     = int'(seen_inc) > int'(r_eff);
      emit_eol = in_data.last_in_line && (r_eff == '0);
    end else if (adv_virt) begin
      emit     = (int'(vstep_r) + int'(seen_r)) >= int'(r_eff);
      emit_eol = (vstep_inc == r_eff);
    end
  end

  always_comb begin
    head_word.sample = in_data.sample;
    head_word.tag    = adv_real ? TAG_REAL : TAG_RIGHT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      flush_r   <= 1'b0;
      vstep_r   <= '0;
      iss_v_r   <= 1'b0;
      iss_eol_r <= 1'b0;
    end else begin
      iss_v_r   <= emit;
      iss_eol_r <= emit && emit_eol;
      if (adv_real) begin
        if (!in_data.last_in_line) begin
          seen_r <= seen_inc;
        end else if (r_eff == '0) begin
          seen_r <= '0;
        end else begin
          seen_r  <= seen_inc;
          flush_r <= 1'b1;
          vstep_r <= '0;
        end
      end else if (adv_virt) begin
        vstep_r <= vstep_inc;
        if (vstep_inc == r_eff) begin
          flush_r <= 1'b0;
          seen_r  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_real) begin
      newest_r <= in_data.sample;
      if (seen_r == '0) begin
        first_r <= in_data.sample;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain. A new line marks every older cell as outside the line.
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < NCELLS; j++) begin : g_cell
    cell_ctl_t ctl;

    if (j < NUM_TAP_REGS * TAPS_PER_REG) begin : g_tap
      localparam int TREG = j / TAPS_PER_REG;
      localparam int TPOS = (j % TAPS_PER_REG) * TAP_BITS;
      assign tap_w[j] = taps_r[TREG][TPOS +: TAP_BITS];
    end else begin : g_notap
      assign tap_w[j] = '0;
    end

    assign tap_en[j]   = (j <= 2 * int'(r_eff));
    assign ctl.shift   = shift;
    assign ctl.restart = (j != 0) && restart;

    if (j == 0) begin : g_head
      assign word_d[j] = head_word;
    end else begin : g_link
      assign word_d[j] = word_q[j-1];
    end

    lfir_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .word_in  (word_d[j]),
      .word_out (word_q[j]),
      .border   (border),
      .tap      (tap_w[j]),
      .tap_en   (tap_en[j]),
      .prod     (prod[j])
    );
  end

  // ---------------------------------------------------------------------------
  // Sum, rounding and saturation. The cells form products in the cycle after
  // an issue; the tree adds them in TREE_LV registered levels.
  // ---------------------------------------------------------------------------
  lfir_sum #(
    .N_IN  (NCELLS),
    .IN_W  (PROD_W),
    .OUT_W (ACC_W)
  ) u_sum (
    .clk  (clk),
    .prod (prod),
    .sum  (tree_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= TREE_LV; k++) begin
        pv_r[k] <= 1'b0;
      end
    end else begin
      pv_r[0] <= iss_v_r;
      for (int k = 1; k <= TREE_LV; k++) begin
        pv_r[k] <= pv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    pe_r[0] <= iss_eol_r;
    for (int k = 1; k <= TREE_LV; k++) begin
      pe_r[k] <= pe_r[k-1];
    end
  end

  // Round half up: add half an LSB of the Q1.14 result, then floor-shift.
  assign biased   = tree_sum + ACC_W'(ROUND_BIAS);
  assign shifted  = biased >>> FRAC_BITS;
  assign too_high = shifted > ACC_W'(SAMP_MAX);
  assign too_low  = shifted < ACC_W'(SAMP_MIN);

  always_comb begin
    if (too_high) begin
      result.filtered = SAMPLE_BITS'(SAMP_MAX);
    end else if (too_low) begin
      result.filtered = SAMPLE_BITS'(SAMP_MIN);
    end else begin
      result.filtered = shifted[SAMPLE_BITS-1:0];
    end
    result.end_of_line = pe_r[TREE_LV];
    result.clipped     = too_high || too_low;
  end

  assign fifo_wr = pv_r[TREE_LV];

  lfir_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (fifo_wr),
    .wr_data   (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Words claimed by advances and not yet taken by the receiver.
  assign deliver = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({emit, deliver})
        2'b10:   pend_r <= pend_r + PEND_W'(1);
        2'b01:   pend_r <= pend_r - PEND_W'(1);
        default: pend_r <= pend_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_pend_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(FIFO_DEPTH))
    else $error("more words in flight than queue slots");

  a_out_claimed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != '0))
    else $error("result shown without a claimed queue slot");

  a_wr_claimed: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_wr |-> (pend_r != '0))
    else $error("queue write without a claimed slot");

  a_flush_eol: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(flush_r) |-> (iss_v_r && iss_eol_r))
    else $error("flush ended without issuing the end-of-line result");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the streaming line FIR with zero, constant and edge borders.
`timescale 1ns / 100ps

import lfir_pkg::*;

// Mirrors the filter's register file and sample history, and keeps the
// filtered words that accepted samples are due to produce, oldest first.
class line_fir_mirror;
  localparam int MAX_R     = 7;
  localparam int WIN_DEPTH = 2 * MAX_R + 1;

  logic signed [TAP_BITS-1:0]    taps [WIN_DEPTH];
  int                            radius;
  logic [MODE_W-1:0]             mode;
  logic signed [SAMPLE_BITS-1:0] border_value;
  logic signed [SAMPLE_BITS-1:0] window [WIN_DEPTH];
  logic signed [SAMPLE_BITS-1:0] first_sample;
  int                            seen;
  out_word_t                     pending_filtered [$];
  int                            mismatch_count;

  function new();
    foreach (taps[j]) taps[j] = '0;
    taps[0] = TAPS0_RESET[TAP_BITS-1:0];
    foreach (window[j]) window[j] = '0;
    radius = 0;
    mode = MODE_ZERO;
    border_value = '0;
    first_sample = '0;
    seen = 0;
    mismatch_count = 0;
  endfunction

  function void note_config(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TAPS_0_2, REG_TAPS_3_5, REG_TAPS_6_8, REG_TAPS_9_11, REG_TAPS_12_14: begin
        for (int t = 0; t < TAPS_PER_REG; t++)
          taps[int'(idx) * TAPS_PER_REG + t] = data[TAP_BITS*t +: TAP_BITS];
      end
      REG_RADIUS: begin
        radius = (int'(data[RADIUS_W-1:0]) > MAX_R) ? MAX_R : int'(data[RADIUS_W-1:0]);
      end
      REG_MODE: mode = data[MODE_W-1:0];
      REG_BVAL: border_value = data[SAMPLE_BITS-1:0];
      default: ;
    endcase
  endfunction

  // e is the distance from the newest sample back to the output position.
  function out_word_t position_result(int e, int r, logic signed [SAMPLE_BITS-1:0] newest,
                                      bit eol);
    longint    acc;
    longint    v;
    longint    s;
    int        d;
    out_word_t w;
    acc = 0;
    for (int k = -r; k <= r; k++) begin
      d = e - k;
      if (d < 0 || d > seen - 1) begin
        if (mode == MODE_CONST) s = border_value;
        else if (mode == MODE_EDGE) s = (d < 0) ? newest : first_sample;
        else s = 0;
      end else begin
        s = window[d];
      end
      acc += s * taps[r - k];
    end
    v = (acc + ROUND_BIAS) >>> FRAC_BITS;
    w.clipped = 1'b0;
    if (v > SAMP_MAX) begin
      v = SAMP_MAX;
      w.clipped = 1'b1;
    end else if (v < SAMP_MIN) begin
      v = SAMP_MIN;
      w.clipped = 1'b1;
    end
    w.filtered = v[SAMPLE_BITS-1:0];
    w.end_of_line = eol;
    return w;
  endfunction

  function void take_sample(in_word_t w);
    int r;
    int cnt;
    for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = w.sample;
    if (seen == 0) first_sample = w.sample;
    if (seen < WIN_DEPTH) seen++;
    r = radius;
    if (!w.last_in_line) begin
      if (seen > r) pending_filtered.push_back(position_result(r, r, w.sample, 1'b0));
    end else begin
      cnt = (seen < r + 1) ? seen : r + 1;
      for (int j = 0; j < cnt; j++)
        pending_filtered.push_back(position_result(cnt - 1 - j, r, w.sample, (cnt - 1 - j) == 0));
      seen = 0;
    end
  endfunction

  task report_mismatch(string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task check_filtered(out_word_t got);
    out_word_t want;
    if (pending_filtered.size() == 0) begin
      report_mismatch($sformatf("word %0d/%b/%b with nothing due",
                                got.filtered, got.end_of_line, got.clipped));
      return;
    end
    want = pending_filtered.pop_front();
    if (got.filtered !== want.filtered)
      report_mismatch($sformatf("filtered %0d, due %0d", got.filtered, want.filtered));
    if (got.end_of_line !== want.end_of_line)
      report_mismatch($sformatf("end_of_line %b, due %b", got.end_of_line, want.end_of_line));
    if (got.clipped !== want.clipped)
      report_mismatch($sformatf("clipped %b, due %b (filtered %0d)",
                                got.clipped, want.clipped, want.filtered));
  endtask
endclass

module tb_top;
  // A generous ceiling on the length of the whole run.
  localparam int CYCLE_LIMIT = 200000;
  // Words with no result of their own may still be in the pipeline when the
  // last due word arrives, so wait longer.
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT = 13;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // When calm is set, neither side idles: this gives a long stretch of
  // back-to-back traffic in the middle of the run.
  bit calm = 1'b0;
  int cycle_count = 0;
  logic signed [TAP_BITS-1:0] coef_plan [15];
  line_fir_mirror fir;

  line_fir_with_border_modes dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The watchdog counts cycles and fails the run if it never finishes.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // The receiver stalls at random, changing its mind only at falling edges.
  initial begin
    @(negedge clk);
    forever begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      @(negedge clk);
    end
  end

  // Every word taken at a rising edge is checked against the oldest due word.
  // Outputs are read in the edge's active region, before any flop updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) fir.check_filtered(out_data);
  end

  // Offers one sample word, after an optional random gap, and holds it until
  // the filter takes it. Called and returns at a falling edge.
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, bit last);
    in_word_t w;
    w.sample = s;
    w.last_in_line = last;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    fir.take_sample(w);
    @(negedge clk);
  endtask

  // Stops sending and waits until every due word has come out and the
  // pipeline has emptied. Register writes are only safe after this.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (fir.pending_filtered.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // One register write. A quiet gap with cfg_valid low follows, so that
  // cfg_valid is never lowered and raised in the same step.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    fir.note_config(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Writes all eight registers: the taps from coef_plan, and the narrow
  // fields with random junk above them that the filter must ignore.
  task automatic program_filter(int r, logic [MODE_W-1:0] mode,
                                logic signed [SAMPLE_BITS-1:0] bval);
    logic [CFG_DATA_W-1:0] junk;
    for (int g = 0; g < NUM_TAP_REGS; g++)
      write_reg(cfg_reg_t'(g), {coef_plan[3*g+2], coef_plan[3*g+1], coef_plan[3*g]});
    junk = CFG_DATA_W'({$urandom(), $urandom()});
    write_reg(REG_RADIUS, {junk[CFG_DATA_W-1:RADIUS_W], RADIUS_W'(r)});
    junk = CFG_DATA_W'({$urandom(), $urandom()});
    write_reg(REG_MODE, {junk[CFG_DATA_W-1:MODE_W], mode});
    junk = CFG_DATA_W'({$urandom(), $urandom()});
    write_reg(REG_BVAL, {junk[CFG_DATA_W-1:SAMPLE_BITS], bval});
  endtask

  // Fills coef_plan. Wild taps span the whole Q1.14 range and clip often;
  // tame taps are scaled to the kernel width so most sums stay in range.
  // Taps beyond 2R get values too, since the filter must ignore them.
  function automatic void plan_taps(int r, bit wild);
    int span;
    int c;
    span = 16384 / (2 * r + 1);
    foreach (coef_plan[j]) begin
      c = int'($urandom_range(0, 2 * span)) - span;
      coef_plan[j] = wild ? TAP_BITS'($urandom()) : TAP_BITS'(c);
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int c;
    c = int'($urandom_range(0, 200)) - 100;
    case ($urandom_range(0, 9))
      0: return SAMPLE_BITS'(SAMP_MAX);
      1: return SAMPLE_BITS'(SAMP_MIN);
      2, 3: return SAMPLE_BITS'(c);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  initial begin
    int r;
    int len;
    int sent;
    logic [MODE_W-1:0] mode;
    logic signed [SAMPLE_BITS-1:0] bval;

    fir = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: radius 0 and tap 0 at 1.0 pass samples straight
    // through. The last word is a line of a single sample.
    send_sample(SAMPLE_BITS'(SAMP_MAX), 1'b0);
    send_sample(SAMPLE_BITS'(SAMP_MIN), 1'b0);
    send_sample('0, 1'b1);
    send_sample(-16'sd1, 1'b1);
    wait_drained();

    // Largest positive taps, widest kernel, edge replication: a line shorter
    // than R+1 flushes all of its positions at its last sample and clips high.
    foreach (coef_plan[j]) coef_plan[j] = 16'sh7FFF;
    program_filter(7, MODE_EDGE, '0);
    send_sample(SAMPLE_BITS'(SAMP_MAX), 1'b0);
    send_sample(SAMPLE_BITS'(SAMP_MAX), 1'b0);
    send_sample(SAMPLE_BITS'(SAMP_MAX), 1'b1);
    wait_drained();

    // Most negative taps against the most negative constant border.
    foreach (coef_plan[j]) coef_plan[j] = 16'sh8000;
    program_filter(7, MODE_CONST, SAMPLE_BITS'(SAMP_MIN));
    send_sample(SAMPLE_BITS'(SAMP_MIN), 1'b0);
    send_sample(SAMPLE_BITS'(SAMP_MIN), 1'b1);
    wait_drained();

    // A tap of one half shows rounding half up on odd samples of both signs.
    foreach (coef_plan[j]) coef_plan[j] = '0;
    coef_plan[0] = 16'sh2000;
    program_filter(0, MODE_ZERO, '0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd3, 1'b1);
    wait_drained();

    // The unused border mode pads with zeros. The radius is changed twice in
    // the middle of a line, with the sender paused until the filter is idle;
    // the new radius applies to the samples already held.
    plan_taps(5, 1'b0);
    program_filter(2, MODE_UNUSED, 16'sh1234);
    repeat (4) send_sample(pick_sample(), 1'b0);
    wait_drained();
    write_reg(REG_RADIUS, CFG_DATA_W'(5));
    repeat (4) send_sample(pick_sample(), 1'b0);
    wait_drained();
    write_reg(REG_RADIUS, CFG_DATA_W'(1));
    repeat (3) send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);
    wait_drained();

    // Random phases: each one reprograms every register and then streams
    // whole lines of random length, some longer than the sample window.
    // The first two phases pin the radius to its extremes, and the fourth
    // runs with no idling on either side.
    for (int ph = 0; ph < 7; ph++) begin
      calm = (ph == 3);
      r = (ph == 0) ? 7 : (ph == 1) ? 0 : int'($urandom_range(0, 7));
      mode = MODE_W'(ph);
      case ($urandom_range(0, 3))
        0: bval = SAMPLE_BITS'(SAMP_MAX);
        1: bval = SAMPLE_BITS'(SAMP_MIN);
        default: bval = SAMPLE_BITS'($urandom());
      endcase
      plan_taps(r, $urandom_range(0, 3) == 0);
      program_filter(r, mode, bval);
      sent = 0;
      while (sent < 14) begin
        len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(16, 24))
                                          : int'($urandom_range(1, 2 * r + 3));
        for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
        sent += len;
      end
      wait_drained();
    end
    calm = 1'b0;

    if (fir.mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
